// ===== hw/rtl/lctfs_pkg.sv =====
// lctfs_pkg: widths, status codes and register indexes shared by the
// load-cell tare/filter/scale core and its iterative divider.
// No dependencies.
package lctfs_pkg;

  // field widths
  localparam int SAMPLE_W = 24;
  localparam int GRAM_W   = 25;
  localparam int CNT_W    = 32;
  localparam int SCALE_W  = 16;
  localparam int SHIFT_W  = 4;
  localparam int TARE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 2;

  // tare accumulator width
  localparam int SUM_W = 32;

  // divider operand widths
  localparam int DVD_W = 32;
  localparam int DVS_W = 16;

  // filter step exponent cap
  localparam int MAX_SHIFT = 6;

  // reading that flags a bad conversion
  localparam logic signed [SAMPLE_W-1:0] INVALID_SAMPLE = '1;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [INDEX_W-1:0] REG_SHIFT = 2'd1;
  localparam logic [INDEX_W-1:0] REG_TARE  = 2'd2;

  // configuration reset values
  localparam logic signed [SCALE_W-1:0] SCALE_RST = 16'sd1;
  localparam logic [SHIFT_W-1:0]        SHIFT_RST = 4'd3;
  localparam logic [TARE_W-1:0]         TARE_RST  = 8'd16;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_MEASURED     = 3'd0,
    STATUS_TARE_PENDING = 3'd1,
    STATUS_TARE_DONE    = 3'd2,
    STATUS_MISSED       = 3'd3,
    STATUS_INVALID      = 3'd4
  } status_t;

endpackage

// ===== hw/rtl/lctfs_div.sv =====
// lctfs_div: signed restoring divider, one quotient bit per cycle,
// quotient truncated toward zero. Depends on lctfs_pkg.
module lctfs_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [lctfs_pkg::DVD_W-1:0]   dividend,
  input  logic signed [lctfs_pkg::DVS_W-1:0]   divisor,
  output logic                                 done,
  output logic signed [lctfs_pkg::DVD_W-1:0]   quotient
);
  import lctfs_pkg::*;

  localparam int CNT_BITS = $clog2(DVD_W);

  logic [DVD_W-1:0]    dvd_abs;
  logic [DVS_W-1:0]    dvs_abs;
  logic [DVD_W-1:0]    quo;
  logic [DVS_W-1:0]    rem;
  logic [DVS_W-1:0]    dvs;
  logic                neg;
  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DVS_W+1:0]    trial;
  logic                fits;

  // operand magnitudes
  always_comb begin
    dvd_abs = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
    dvs_abs = divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
  end

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial = {1'b0, rem, quo[DVD_W-1]} - {2'b00, dvs};
    fits  = !trial[DVS_W+1];
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      quo  <= dvd_abs;
      rem  <= '0;
      dvs  <= dvs_abs;
      neg  <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
      cnt  <= CNT_BITS'(DVD_W - 1);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem  <= fits ? trial[DVS_W-1:0] : {rem[DVS_W-2:0], quo[DVD_W-1]};
      quo  <= {quo[DVD_W-2:0], fits};
      cnt  <= cnt - 1'b1;
      busy <= (cnt != '0);
      done <= (cnt == '0);
    end else begin
      done <= 1'b0;
    end
  end

  // sign of the result
  assign quotient = neg ? -signed'(quo) : signed'(quo);

endmodule

// ===== hw/rtl/load_cell_tare_filter_scale_core.sv =====
// load_cell_tare_filter_scale_core: tare averaging, offset removal,
// shift smoothing and gram scaling of load-cell readings.
// Depends on lctfs_pkg and lctfs_div.
//
// Usage: one reading per input transfer (action, sample, read_missed) on a
// valid/ready channel; each transfer gives exactly one result transfer with
// status, gram values, offset, last samples and the three wrap counters.
// Configuration (scale, smoothing shift, tare count) is written through
// cfg_we/cfg_index/cfg_data while no item is in flight; writes to unused
// indexes are dropped.
// Flow: one item at a time, in_ready is high only when the sequencer is
// idle. A missed or invalid reading, and a tare reading that does not
// finish the tare, go straight to the output register; a tare-finishing
// reading runs one 32-step divide; a measure reading runs two 32-step
// divides (counts and filtered counts by the scale), one after the other on
// the shared one-bit-per-cycle divider.
// The result sits in an output register: the core takes the next item while
// a result waits, and holds its next result until the receiver takes the
// previous one. Reset restores scale 1, shift 3, tare count 16 and clears
// offset, filter, sample registers, counters and the output valid.
module load_cell_tare_filter_scale_core (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration
  input  logic                                    cfg_we,
  input  logic [lctfs_pkg::INDEX_W-1:0]           cfg_index,
  input  logic [lctfs_pkg::SCALE_W-1:0]           cfg_data,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    action,
  input  logic signed [lctfs_pkg::SAMPLE_W-1:0]   sample,
  input  logic                                    read_missed,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [lctfs_pkg::STATUS_W-1:0]          status,
  output logic signed [lctfs_pkg::GRAM_W-1:0]     smoothed_grams,
  output logic signed [lctfs_pkg::GRAM_W-1:0]     instant_grams,
  output logic signed [lctfs_pkg::SAMPLE_W-1:0]   zero_offset,
  output logic signed [lctfs_pkg::SAMPLE_W-1:0]   last_good_sample,
  output logic signed [lctfs_pkg::SAMPLE_W-1:0]   last_attempt_sample,
  output logic [lctfs_pkg::CNT_W-1:0]             updates_done,
  output logic [lctfs_pkg::CNT_W-1:0]             misses_seen,
  output logic [lctfs_pkg::CNT_W-1:0]             invalids_seen
);
  import lctfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV_INST,
    ST_DIV_GRAMS,
    ST_DIV_TARE,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic signed [SCALE_W-1:0] cfg_scale;
  logic [SHIFT_W-1:0]        cfg_shift;
  logic [TARE_W-1:0]         cfg_tare;

  // block state
  logic signed [SAMPLE_W-1:0] offset_reg;
  logic signed [GRAM_W-1:0]   filtered_counts;
  logic                       filter_primed;
  logic signed [GRAM_W-1:0]   grams_reg;
  logic signed [GRAM_W-1:0]   instant_reg;
  logic signed [SAMPLE_W-1:0] good_sample_reg;
  logic signed [SAMPLE_W-1:0] attempt_sample_reg;
  logic signed [SUM_W-1:0]    tare_sum;
  logic [TARE_W-1:0]          tare_accepted;
  logic [CNT_W-1:0]           update_counter;
  logic [CNT_W-1:0]           miss_counter;
  logic [CNT_W-1:0]           invalid_counter;

  // per-item working registers
  logic signed [GRAM_W-1:0]   counts;
  logic signed [SAMPLE_W-1:0] raw_hold;
  status_t                    status_reg;

  // output registers
  status_t                    out_status;

  // derived values
  logic                       in_fire;
  logic signed [SCALE_W-1:0]  scale_eff;
  logic [TARE_W-1:0]          tare_need;
  logic [SHIFT_W-1:0]         shift_eff;
  logic signed [SUM_W-1:0]    sum_new;
  logic [TARE_W:0]            tare_inc;
  logic                       tare_complete;
  logic                       is_invalid;
  logic signed [GRAM_W-1:0]   counts_new;

  // filter step
  logic signed [GRAM_W:0]     diff;
  logic signed [GRAM_W:0]     bias;
  logic signed [GRAM_W:0]     step;
  logic signed [GRAM_W-1:0]   filt_new;

  // divider hookup
  logic                       div_start;
  logic signed [DVD_W-1:0]    div_dividend;
  logic signed [DVS_W-1:0]    div_divisor;
  logic                       div_done;
  logic signed [DVD_W-1:0]    div_quotient;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // effective configuration
  always_comb begin
    scale_eff = (cfg_scale == '0) ? SCALE_W'(1) : cfg_scale;
    tare_need = (cfg_tare == '0) ? TARE_W'(1) : cfg_tare;
    shift_eff = (cfg_shift > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : cfg_shift;
  end

  // input-side arithmetic
  always_comb begin
    is_invalid    = (sample == INVALID_SAMPLE);
    sum_new       = tare_sum + SUM_W'(sample);
    tare_inc      = {1'b0, tare_accepted} + 1'b1;
    tare_complete = (tare_inc >= {1'b0, tare_need});
    counts_new    = GRAM_W'(sample) - GRAM_W'(offset_reg);
  end

  // smoothing step: signed divide by a power of two, at least one count
  always_comb begin
    diff = (GRAM_W+1)'(counts) - (GRAM_W+1)'(filtered_counts);
    bias = diff[GRAM_W] ? (((GRAM_W+1)'(1) << shift_eff) - 1'b1) : '0;
    step = (diff + bias) >>> shift_eff;
    if (step == '0 && diff != '0) begin
      step = diff[GRAM_W] ? -(GRAM_W+1)'(1) : (GRAM_W+1)'(1);
    end
    filt_new = filtered_counts + step[GRAM_W-1:0];
  end

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DVD_W'(counts);
    div_divisor  = scale_eff;
    unique case (state)
      ST_IDLE: begin
        div_start    = in_fire && !read_missed && !is_invalid && action && tare_complete;
        div_dividend = DVD_W'(sum_new);
        div_divisor  = DVS_W'({1'b0, tare_need});
      end
      ST_CALC: begin
        div_start = 1'b1;
      end
      ST_DIV_INST: begin
        div_start    = div_done;
        div_dividend = DVD_W'(filtered_counts);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lctfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_scale <= SCALE_RST;
      cfg_shift <= SHIFT_RST;
      cfg_tare  <= TARE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE: cfg_scale <= cfg_data;
        REG_SHIFT: cfg_shift <= cfg_data[SHIFT_W-1:0];
        REG_TARE:  cfg_tare  <= cfg_data[TARE_W-1:0];
        default:   ;
      endcase
    end
  end

  // sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      offset_reg         <= '0;
      filtered_counts    <= '0;
      filter_primed      <= 1'b0;
      grams_reg          <= '0;
      instant_reg        <= '0;
      good_sample_reg    <= '0;
      attempt_sample_reg <= '0;
      tare_sum           <= '0;
      tare_accepted      <= '0;
      update_counter     <= '0;
      miss_counter       <= '0;
      invalid_counter    <= '0;
      status_reg         <= STATUS_MEASURED;
      out_valid          <= 1'b0;
    end else begin
      // output slot frees on transfer unless a new result loads it
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            raw_hold <= sample;
            counts   <= counts_new;
            if (read_missed) begin
              miss_counter  <= miss_counter + 1'b1;
              tare_sum      <= '0;
              tare_accepted <= '0;
              status_reg    <= STATUS_MISSED;
              state         <= ST_FINISH;
            end else if (is_invalid) begin
              attempt_sample_reg <= sample;
              invalid_counter    <= invalid_counter + 1'b1;
              tare_sum           <= '0;
              tare_accepted      <= '0;
              status_reg         <= STATUS_INVALID;
              state              <= ST_FINISH;
            end else if (action) begin
              attempt_sample_reg <= sample;
              if (tare_complete) begin
                tare_sum      <= '0;
                tare_accepted <= '0;
                status_reg    <= STATUS_TARE_DONE;
                state         <= ST_DIV_TARE;
              end else begin
                tare_sum      <= sum_new;
                tare_accepted <= tare_inc[TARE_W-1:0];
                status_reg    <= STATUS_TARE_PENDING;
                state         <= ST_FINISH;
              end
            end else begin
              attempt_sample_reg <= sample;
              good_sample_reg    <= sample;
              update_counter     <= update_counter + 1'b1;
              tare_sum           <= '0;
              tare_accepted      <= '0;
              status_reg         <= STATUS_MEASURED;
              state              <= ST_CALC;
            end
          end
        end

        // filter update, instant divide starts
        ST_CALC: begin
          if (!filter_primed) begin
            filtered_counts <= counts;
            filter_primed   <= 1'b1;
          end else begin
            filtered_counts <= filt_new;
          end
          state <= ST_DIV_INST;
        end

        ST_DIV_INST: begin
          if (div_done) begin
            instant_reg <= div_quotient[GRAM_W-1:0];
            state       <= ST_DIV_GRAMS;
          end
        end

        ST_DIV_GRAMS: begin
          if (div_done) begin
            grams_reg <= div_quotient[GRAM_W-1:0];
            state     <= ST_FINISH;
          end
        end

        // new zero offset, filter restarts
        ST_DIV_TARE: begin
          if (div_done) begin
            offset_reg      <= div_quotient[SAMPLE_W-1:0];
            good_sample_reg <= raw_hold;
            grams_reg       <= '0;
            instant_reg     <= '0;
            filtered_counts <= '0;
            filter_primed   <= 1'b0;
            state           <= ST_FINISH;
          end
        end

        // load the output register once it is free
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_status          <= status_reg;
            smoothed_grams      <= grams_reg;
            instant_grams       <= instant_reg;
            zero_offset         <= offset_reg;
            last_good_sample    <= good_sample_reg;
            last_attempt_sample <= attempt_sample_reg;
            updates_done        <= update_counter;
            misses_seen         <= miss_counter;
            invalids_seen       <= invalid_counter;
            state               <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign status = out_status;

endmodule
